[design/note_onset_detector_with_holdoff_core_macros.svh]
// assertion macros used by the onset detector top level
`ifndef NOTE_ONSET_DETECTOR_WITH_HOLDOFF_CORE_MACROS_SVH
`define NOTE_ONSET_DETECTOR_WITH_HOLDOFF_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define OND_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("onset detector check failed");

// next-cycle implication, sampled on clk, off during reset
`define OND_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("onset detector check failed");

`endif

[design/ond_pkg.sv]
// shared types and constants of the onset detector
package ond_pkg;

  localparam int NUM_CHANNELS_DEF = 64;
  localparam int CHAN_W           = 6;
  localparam int ACT_W            = 16;
  localparam int FRAME_W          = 24;
  localparam int HOLD_W           = 8;
  localparam int NOTE_W           = 8;
  localparam int LNOTE_W          = 7;
  localparam int PADDR_W          = 4;
  localparam int PDATA_W          = 32;
  localparam int REG_IDX_W        = 2;

  // register indexes, byte address is 4 * index
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HOLDOFF     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOWEST_NOTE = 2'd2;

  // item opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [ACT_W-1:0]   THRESHOLD_RST   = 16'd32768;
  localparam logic [HOLD_W-1:0]  HOLDOFF_RST     = 8'd3;
  localparam logic [LNOTE_W-1:0] LOWEST_NOTE_RST = 7'd40;

  typedef struct packed {
    logic [ACT_W-1:0]   threshold;
    logic [HOLD_W-1:0]  holdoff_frames;
    logic [LNOTE_W-1:0] lowest_note;
  } cfg_t;

  // per-channel state word kept in memory
  typedef struct packed {
    logic              prev_active;
    logic [HOLD_W-1:0] holdoff;
  } chan_state_t;

endpackage

[design/ond_cfg_regs.sv]
// configuration registers behind the apb-style port
module ond_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ond_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [ond_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [ond_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready,
  output ond_pkg::cfg_t               cfg
);
  import ond_pkg::*;

  cfg_t                 cfg_r, cfg_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx    = cfg_paddr[PADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_THRESHOLD:   cfg_nxt.threshold      = cfg_pwdata[ACT_W-1:0];
        REG_HOLDOFF:     cfg_nxt.holdoff_frames = cfg_pwdata[HOLD_W-1:0];
        REG_LOWEST_NOTE: cfg_nxt.lowest_note    = cfg_pwdata[LNOTE_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD:   cfg_prdata = {{(PDATA_W-ACT_W){1'b0}}, cfg_r.threshold};
      REG_HOLDOFF:     cfg_prdata = {{(PDATA_W-HOLD_W){1'b0}}, cfg_r.holdoff_frames};
      REG_LOWEST_NOTE: cfg_prdata = {{(PDATA_W-LNOTE_W){1'b0}}, cfg_r.lowest_note};
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold      <= THRESHOLD_RST;
      cfg_r.holdoff_frames <= HOLDOFF_RST;
      cfg_r.lowest_note    <= LOWEST_NOTE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[design/ond_chan_mem.sv]
// per-channel state memory, registered read, valid bit per entry
module ond_chan_mem #(
  parameter int DEPTH = ond_pkg::NUM_CHANNELS_DEF,
  parameter int IDX_W = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output ond_pkg::chan_state_t rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  ond_pkg::chan_state_t wr_data
);
  import ond_pkg::*;

  chan_state_t            mem [DEPTH];
  logic [DEPTH-1:0]       valid_r, valid_nxt;
  chan_state_t            rdata_r;
  logic                   rvalid_r;

  // entry not written since reset or clear reads as zero
  assign rd_data = rvalid_r ? rdata_r : '0;

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) valid_nxt[wr_addr] = 1'b1;
    if (clear) valid_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (rd_en) rvalid_r <= valid_r[rd_addr];
    end
  end

endmodule

[design/note_onset_detector_with_holdoff_core.sv]
// top level of the per-pitch onset detector with holdoff
// One item per cycle sustained while input stall is low. A sample item is
// accepted at a clock edge and starts a read of its channel's state word
// (previous-active flag and holdoff counter) from a one-read, one-write memory
// with a registered read. In the next cycle the evaluate stage compares the
// activation with the threshold and decides on an onset; when it advances it
// writes the updated word back and, on an onset, loads the output register.
// A sample that follows one of the same channel directly gets the freshly
// written word through a bypass register, so back-to-back samples of one
// channel need no bubble. A clear item takes effect at its acceptance edge by
// dropping every entry's valid bit and gives no result. Samples whose channel
// is at or above NUM_CHANNELS pass through without touching state or giving a
// result. The output register decouples the sides: input stall rises only
// while the evaluate stage holds an item and an earlier result waits in the
// output register with the receiver stalling, whether or not that item is an
// onset.
module note_onset_detector_with_holdoff_core #(
  parameter int NUM_CHANNELS = ond_pkg::NUM_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // sample input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [ond_pkg::CHAN_W-1:0]  in_channel,
  input  logic [ond_pkg::ACT_W-1:0]   in_activation,
  input  logic [ond_pkg::FRAME_W-1:0] in_frame_number,
  // onset results
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ond_pkg::NOTE_W-1:0]  out_note_number,
  output logic [ond_pkg::FRAME_W-1:0] out_event_frame,
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ond_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [ond_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [ond_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import ond_pkg::*;

`include "note_onset_detector_with_holdoff_core_macros.svh"

  // the channel field reaches 64 channels at most
  localparam int MEM_DEPTH = (NUM_CHANNELS > 64) ? 64 : NUM_CHANNELS;
  localparam int IDX_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  cfg_t cfg;

  ond_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // input side
  logic             in_accept;
  logic             in_is_clear;
  logic             in_live;
  logic [IDX_W-1:0] in_idx;

  // evaluate stage
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_live_r;
  logic [CHAN_W-1:0]    s1_channel_r;
  logic [ACT_W-1:0]     s1_act_r;
  logic [FRAME_W-1:0]   s1_frame_r;
  logic                 s1_adv;
  logic                 s1_we;
  logic                 s1_hit;
  logic                 s1_active;
  logic [IDX_W-1:0]     s1_idx;
  chan_state_t          s1_cur;
  chan_state_t          s1_new;
  chan_state_t          mem_rdata;

  // bypass of the word written at the edge where this item was read
  logic                 fwd_hit_r;
  chan_state_t          fwd_data_r;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [NOTE_W-1:0]    out_note_r;
  logic [FRAME_W-1:0]   out_frame_r;

  assign in_is_clear = (in_opcode == OP_CLEAR);
  assign in_idx      = in_channel[IDX_W-1:0];
  assign in_live     = !in_is_clear &&
                       ({2'b00, in_channel} < NUM_CHANNELS[CHAN_W+1:0]);

  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  assign s1_idx = s1_channel_r[IDX_W-1:0];
  assign s1_cur = fwd_hit_r ? fwd_data_r : mem_rdata;
  assign s1_active = (s1_act_r >= cfg.threshold);

  // holdoff countdown wins over detection
  always_comb begin
    s1_new.prev_active = s1_active;
    s1_new.holdoff     = s1_cur.holdoff;
    s1_hit             = 1'b0;
    priority if (s1_cur.holdoff != '0) begin
      s1_new.holdoff = s1_cur.holdoff - HOLD_W'(1);
    end else if (s1_active && !s1_cur.prev_active) begin
      s1_new.holdoff = cfg.holdoff_frames;
      s1_hit         = s1_live_r;
    end else begin
      s1_new.holdoff = s1_cur.holdoff;
    end
  end

  assign s1_we = s1_adv && s1_live_r;

  ond_chan_mem #(
    .DEPTH (MEM_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (in_accept && in_is_clear),
    .rd_en   (in_accept && in_live),
    .rd_addr (in_idx),
    .rd_data (mem_rdata),
    .wr_en   (s1_we),
    .wr_addr (s1_idx),
    .wr_data (s1_new)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_adv) s1_valid_nxt = 1'b0;
    if (in_accept && !in_is_clear) s1_valid_nxt = 1'b1;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (s1_adv && s1_hit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_live_r    <= in_live;
      s1_channel_r <= in_channel;
      s1_act_r     <= in_activation;
      s1_frame_r   <= in_frame_number;
      fwd_hit_r    <= s1_we && (s1_idx == in_idx);
      fwd_data_r   <= s1_new;
    end
    if (s1_adv && s1_hit) begin
      out_note_r  <= {1'b0, cfg.lowest_note} + {2'b00, s1_channel_r};
      out_frame_r <= s1_frame_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_note_number = out_note_r;
  assign out_event_frame = out_frame_r;

  // an accepted item never overwrites a stage that is still held
  `OND_ASSERT_IMPL(a_no_overrun, in_accept && s1_valid_r, s1_adv)
  // a reported onset always arms the holdoff counter with the register value
  `OND_ASSERT_IMPL(a_onset_loads, s1_adv && s1_hit, s1_new.holdoff == cfg.holdoff_frames)
  // a clear item never occupies the evaluate stage
  `OND_ASSERT_NEXT(a_clear_bubble, in_accept && in_is_clear, !s1_valid_r)
  // a result comes only with a live sample leaving the evaluate stage
  `OND_ASSERT_IMPL(a_hit_live, s1_hit, s1_live_r && s1_cur.holdoff == '0)

endmodule
